// File: hw/rtl/srre_pkg.sv
// shared types and constants for the span to region run encoder
package srre_pkg;

    localparam logic signed [15:0] SENTINEL_RESET = 16'sh7FFF;
    localparam logic signed [15:0] WORD_MAX       = 16'sh7FFF;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_CMP      = 7'b0000100,
        S_LINE     = 7'b0001000,
        S_GAP      = 7'b0010000,
        S_APPLY    = 7'b0100000,
        S_FINAL    = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        LP_BOT  = 3'b001,
        LP_XS   = 3'b010,
        LP_SENT = 3'b100
    } line_phase_t;

    typedef enum logic [1:0] {
        NX_FINAL = 2'd0,
        NX_CURR  = 2'd1,
        NX_GAP   = 2'd2,
        NX_APPLY = 2'd3
    } line_next_t;

    typedef enum logic {
        SRC_PREV = 1'b0,
        SRC_CURR = 1'b1
    } line_src_t;

    typedef struct packed {
        logic en;
        logic pair;
    } xs_wr_t;

endpackage

// File: hw/rtl/srre_xs_store.sv
// ping-pong x value store: one bank holds the previous line, the other the current one
module srre_xs_store #(
    parameter int MAX_XS = 16
) (
    input  logic                        clk,
    input  logic                        prev_bank,
    input  srre_pkg::xs_wr_t            wr,
    input  logic [$clog2(MAX_XS)-1:0]   wr_idx,
    input  logic signed [15:0]          wr_data_a,
    input  logic signed [15:0]          wr_data_b,
    input  logic [$clog2(MAX_XS)-1:0]   rd_idx,
    output logic signed [15:0]          prev_rd,
    output logic signed [15:0]          curr_rd
);

    localparam int IW = $clog2(MAX_XS);

    logic signed [15:0] bank_reg [2][MAX_XS];
    logic               cur_bank;
    logic [IW-1:0]      wr_idx_b;

    assign cur_bank = ~prev_bank;
    assign wr_idx_b = wr_idx + IW'(1);

    // writes go to the current bank only; a pair writes x then right edge
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 2; b++)
        begin
            for (int e = 0; e < MAX_XS; e++)
            begin
                if (wr.en && (1'(b) == cur_bank))
                begin
                    if (IW'(e) == wr_idx)
                    begin
                        bank_reg[b][e] <= wr_data_a;
                    end
                    else if (wr.pair && (IW'(e) == wr_idx_b))
                    begin
                        bank_reg[b][e] <= wr_data_b;
                    end
                end
            end
        end
    end

    assign prev_rd = bank_reg[prev_bank][rd_idx];
    assign curr_rd = bank_reg[cur_bank][rd_idx];

endmodule

// File: hw/rtl/span_to_region_run_encoder_core.sv
// top level of the span to region run encoder: sequencer, line state and output register
//
// Input channel (in_valid / in_stall): mode 0 carries one span (span_x, span_y,
// span_width) in scanline order, mode 1 finishes the region and flushes it.
// Output channel (out_valid / out_stall): one signed 16-bit word of the region
// run stream per transfer; last marks the final sentinel, empty_res a finish
// with no spans, overflow a dropped span in this region.
// A span on the current line, the first span and a finish with no spans are
// accepted, then merged, appended or answered with one word out.
// A span that opens a new line walks the x lists with one shared index and
// comparator: accept, dispatch, bank swap and append, a fold test over up to N
// x values (N = x values on the line) and the emitted words, bottom + N +
// sentinel per line and one more line across a vertical gap.
// A finish runs the fold test and emits its words, the closing sentinel
// included; a stalled word holds the sequencer.
// The single output register sets the word rate; when the receiver stalls the
// sequencer waits on it and in_stall stays high until the item is done.
// Reset clears the line state and loads the sentinel with 32767; there is no
// clearing pass. cfg_wr_en / cfg_wr_data replace the sentinel word; the user
// must write them only while the block is idle; the block does not enforce it.
module span_to_region_run_encoder_core #(
    parameter int MAX_XS_PER_LINE = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [15:0] span_x,
    input  logic signed [15:0] span_y,
    input  logic [14:0]        span_width,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] word,
    output logic               last,
    output logic               empty_res,
    output logic               overflow,
    input  logic               cfg_wr_en,
    input  logic signed [15:0] cfg_wr_data
);

    localparam int CW = $clog2(MAX_XS_PER_LINE + 1);
    localparam int IW = $clog2(MAX_XS_PER_LINE);

    srre_pkg::state_t      state_reg, state_next;
    srre_pkg::line_phase_t phase_reg, phase_next;
    srre_pkg::line_next_t  nxt_reg, nxt_next;
    srre_pkg::line_src_t   src_reg, src_next;

    logic               mode_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] right_reg;

    logic               started_reg, started_next;
    logic               prev_valid_reg, prev_valid_next;
    logic signed [15:0] prev_last_y_reg, prev_last_y_next;
    logic [CW-1:0]      prev_count_reg, prev_count_next;
    logic signed [15:0] curr_y_reg, curr_y_next;
    logic [CW-1:0]      curr_count_reg, curr_count_next;
    logic signed [15:0] curr_last_reg, curr_last_next;
    logic               overflow_seen_reg, overflow_seen_next;
    logic               sel_reg, sel_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               do_swap_reg, do_swap_next;
    logic               gap_fill_reg, gap_fill_next;
    logic signed [15:0] sentinel_reg;

    logic               out_valid_reg;
    logic signed [15:0] word_reg;
    logic               last_reg;
    logic               empty_reg;
    logic               ovf_reg;

    logic               out_free;
    logic               emit;
    logic signed [15:0] emit_word;
    logic               emit_last;
    logic               emit_empty;
    logic               apply_en;
    logic               apply_fresh;
    logic               clear;

    // right edge of the incoming span, saturated at the top of the range
    logic signed [16:0] right_sum;
    logic signed [15:0] right_in;

    logic signed [16:0] y_ext;
    logic signed [16:0] curr_y_ext;
    logic signed [16:0] prev_y_ext;
    logic               y_gt_curr;
    logic               y_gap;
    logic               hdr_ok;

    logic [CW-1:0]      eff_count;
    logic [CW:0]        sum_count;
    logic [CW-1:0]      count_m1;
    logic               merge;
    logic               ovf_cond;
    srre_pkg::xs_wr_t   wr;
    logic [IW-1:0]      wr_idx;
    logic signed [15:0] wr_data_a;

    logic signed [15:0] prev_rd;
    logic signed [15:0] curr_rd;
    logic signed [15:0] line_y;
    logic [CW-1:0]      line_count;
    logic signed [15:0] line_rd;
    logic signed [15:0] line_bottom;
    logic [CW-1:0]      idx_inc;

    assign right_sum = {span_x[15], span_x} + {2'b00, span_width};
    assign right_in  = (!right_sum[16] && right_sum[15]) ? srre_pkg::WORD_MAX
                                                         : right_sum[15:0];

    assign in_stall = (state_reg != srre_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign y_ext      = {y_reg[15], y_reg};
    assign curr_y_ext = {curr_y_reg[15], curr_y_reg};
    assign prev_y_ext = {prev_last_y_reg[15], prev_last_y_reg};
    assign y_gt_curr  = (y_reg > curr_y_reg);
    assign y_gap      = (y_ext > (curr_y_ext + 17'sd1));
    assign hdr_ok     = prev_valid_reg && ((prev_y_ext + 17'sd1) == curr_y_ext)
                        && (prev_count_reg == curr_count_reg);

    // span merge / append against the current line
    assign apply_fresh = (state_reg == srre_pkg::S_APPLY) || !started_reg;
    assign eff_count   = apply_fresh ? '0 : curr_count_reg;
    assign sum_count   = {1'b0, eff_count} + (CW+1)'(2);
    assign count_m1    = curr_count_reg - CW'(1);
    assign merge       = !apply_fresh && (curr_count_reg != '0) && (curr_last_reg == x_reg);
    assign ovf_cond    = (sum_count > (CW+1)'(MAX_XS_PER_LINE));
    assign wr.en       = apply_en && (merge || !ovf_cond);
    assign wr.pair     = !merge;
    assign wr_idx      = merge ? count_m1[IW-1:0] : eff_count[IW-1:0];
    assign wr_data_a   = merge ? right_reg : x_reg;

    srre_xs_store #(
        .MAX_XS (MAX_XS_PER_LINE)
    ) u_store (
        .clk       (clk),
        .prev_bank (sel_reg),
        .wr        (wr),
        .wr_idx    (wr_idx),
        .wr_data_a (wr_data_a),
        .wr_data_b (right_reg),
        .rd_idx    (idx_reg[IW-1:0]),
        .prev_rd   (prev_rd),
        .curr_rd   (curr_rd)
    );

    assign line_y      = (src_reg == srre_pkg::SRC_PREV) ? prev_last_y_reg : curr_y_reg;
    assign line_count  = (src_reg == srre_pkg::SRC_PREV) ? prev_count_reg : curr_count_reg;
    assign line_rd     = (src_reg == srre_pkg::SRC_PREV) ? prev_rd : curr_rd;
    assign line_bottom = (line_y == srre_pkg::WORD_MAX) ? srre_pkg::WORD_MAX
                                                        : line_y + 16'sd1;
    assign idx_inc     = idx_reg + CW'(1);

    always_comb
    begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        nxt_next           = nxt_reg;
        src_next           = src_reg;
        started_next       = started_reg;
        prev_valid_next    = prev_valid_reg;
        prev_last_y_next   = prev_last_y_reg;
        prev_count_next    = prev_count_reg;
        curr_y_next        = curr_y_reg;
        curr_count_next    = curr_count_reg;
        curr_last_next     = curr_last_reg;
        overflow_seen_next = overflow_seen_reg;
        sel_next           = sel_reg;
        idx_next           = idx_reg;
        do_swap_next       = do_swap_reg;
        gap_fill_next      = gap_fill_reg;
        emit               = 1'b0;
        emit_word          = sentinel_reg;
        emit_last          = 1'b0;
        emit_empty         = 1'b0;
        apply_en           = 1'b0;
        clear              = 1'b0;

        unique case (state_reg)
            srre_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = srre_pkg::S_DISPATCH;
                end
            end

            srre_pkg::S_DISPATCH:
            begin
                if (mode_reg)
                begin
                    if (!started_reg)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_empty = 1'b1;
                        if (out_free)
                        begin
                            clear      = 1'b1;
                            state_next = srre_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = srre_pkg::S_CMP;
                    end
                end
                else if (!started_reg)
                begin
                    // first span: top word goes out at once
                    emit      = 1'b1;
                    emit_word = y_reg;
                    if (out_free)
                    begin
                        started_next = 1'b1;
                        curr_y_next  = y_reg;
                        apply_en     = 1'b1;
                        state_next   = srre_pkg::S_IDLE;
                    end
                end
                else if (y_gt_curr)
                begin
                    idx_next   = '0;
                    state_next = srre_pkg::S_CMP;
                end
                else
                begin
                    apply_en   = 1'b1;
                    state_next = srre_pkg::S_IDLE;
                end
            end

            srre_pkg::S_CMP:
            begin
                logic fold;
                logic nofold;
                fold   = 1'b0;
                nofold = 1'b0;
                priority if (!hdr_ok)
                begin
                    nofold = 1'b1;
                end
                else if (curr_count_reg == '0)
                begin
                    fold = 1'b1;
                end
                else if (prev_rd != curr_rd)
                begin
                    nofold = 1'b1;
                end
                else if (idx_inc == curr_count_reg)
                begin
                    fold = 1'b1;
                end
                else
                begin
                    idx_next = idx_inc;
                end

                if (fold)
                begin
                    prev_last_y_next = curr_y_reg;
                    if (mode_reg)
                    begin
                        state_next = srre_pkg::S_LINE;
                        phase_next = srre_pkg::LP_BOT;
                        src_next   = srre_pkg::SRC_PREV;
                        nxt_next   = srre_pkg::NX_FINAL;
                    end
                    else
                    begin
                        do_swap_next = 1'b0;
                        state_next   = srre_pkg::S_GAP;
                    end
                end
                else if (nofold)
                begin
                    if (mode_reg)
                    begin
                        state_next = srre_pkg::S_LINE;
                        phase_next = srre_pkg::LP_BOT;
                        if (prev_valid_reg)
                        begin
                            src_next = srre_pkg::SRC_PREV;
                            nxt_next = srre_pkg::NX_CURR;
                        end
                        else
                        begin
                            src_next = srre_pkg::SRC_CURR;
                            nxt_next = srre_pkg::NX_FINAL;
                        end
                    end
                    else
                    begin
                        do_swap_next = 1'b1;
                        if (prev_valid_reg)
                        begin
                            state_next = srre_pkg::S_LINE;
                            phase_next = srre_pkg::LP_BOT;
                            src_next   = srre_pkg::SRC_PREV;
                            nxt_next   = srre_pkg::NX_GAP;
                        end
                        else
                        begin
                            state_next = srre_pkg::S_GAP;
                        end
                    end
                end
            end

            srre_pkg::S_LINE:
            begin
                emit = 1'b1;
                unique case (phase_reg)
                    srre_pkg::LP_BOT:
                    begin
                        emit_word = line_bottom;
                        if (out_free)
                        begin
                            idx_next   = '0;
                            phase_next = (line_count == '0) ? srre_pkg::LP_SENT
                                                            : srre_pkg::LP_XS;
                        end
                    end
                    srre_pkg::LP_XS:
                    begin
                        emit_word = line_rd;
                        if (out_free)
                        begin
                            if (idx_inc == line_count)
                            begin
                                phase_next = srre_pkg::LP_SENT;
                            end
                            else
                            begin
                                idx_next = idx_inc;
                            end
                        end
                    end
                    srre_pkg::LP_SENT:
                    begin
                        emit_word = sentinel_reg;
                        if (out_free)
                        begin
                            phase_next = srre_pkg::LP_BOT;
                            unique case (nxt_reg)
                                srre_pkg::NX_FINAL: state_next = srre_pkg::S_FINAL;
                                srre_pkg::NX_CURR:
                                begin
                                    src_next = srre_pkg::SRC_CURR;
                                    nxt_next = srre_pkg::NX_FINAL;
                                end
                                srre_pkg::NX_GAP:   state_next = srre_pkg::S_GAP;
                                srre_pkg::NX_APPLY: state_next = srre_pkg::S_APPLY;
                                default:            state_next = srre_pkg::S_FINAL;
                            endcase
                        end
                    end
                    default:
                    begin
                        emit       = 1'b0;
                        phase_next = srre_pkg::LP_BOT;
                    end
                endcase
            end

            srre_pkg::S_GAP:
            begin
                // unfolded line becomes prev by flipping banks
                if (do_swap_reg)
                begin
                    sel_next         = ~sel_reg;
                    prev_count_next  = curr_count_reg;
                    prev_last_y_next = curr_y_reg;
                    prev_valid_next  = 1'b1;
                end
                if (y_gap)
                begin
                    gap_fill_next = 1'b1;
                    state_next    = srre_pkg::S_LINE;
                    phase_next    = srre_pkg::LP_BOT;
                    src_next      = srre_pkg::SRC_PREV;
                    nxt_next      = srre_pkg::NX_APPLY;
                end
                else
                begin
                    gap_fill_next = 1'b0;
                    state_next    = srre_pkg::S_APPLY;
                end
            end

            srre_pkg::S_APPLY:
            begin
                // an empty filler line stands as prev across a gap
                if (gap_fill_reg)
                begin
                    prev_count_next  = '0;
                    prev_last_y_next = y_reg - 16'sd1;
                    prev_valid_next  = 1'b1;
                end
                curr_y_next = y_reg;
                apply_en    = 1'b1;
                state_next  = srre_pkg::S_IDLE;
            end

            srre_pkg::S_FINAL:
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (out_free)
                begin
                    clear      = 1'b1;
                    state_next = srre_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = srre_pkg::S_IDLE;
            end
        endcase

        if (apply_en)
        begin
            if (merge)
            begin
                curr_last_next = right_reg;
            end
            else if (ovf_cond)
            begin
                overflow_seen_next = 1'b1;
            end
            else
            begin
                curr_count_next = sum_count[CW-1:0];
                curr_last_next  = right_reg;
            end
        end

        if (clear)
        begin
            started_next       = 1'b0;
            prev_valid_next    = 1'b0;
            prev_last_y_next   = '0;
            prev_count_next    = '0;
            curr_y_next        = '0;
            curr_count_next    = '0;
            overflow_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= srre_pkg::S_IDLE;
            phase_reg         <= srre_pkg::LP_BOT;
            nxt_reg           <= srre_pkg::NX_FINAL;
            src_reg           <= srre_pkg::SRC_PREV;
            started_reg       <= 1'b0;
            prev_valid_reg    <= 1'b0;
            prev_last_y_reg   <= '0;
            prev_count_reg    <= '0;
            curr_y_reg        <= '0;
            curr_count_reg    <= '0;
            curr_last_reg     <= '0;
            overflow_seen_reg <= 1'b0;
            sel_reg           <= 1'b0;
            idx_reg           <= '0;
            do_swap_reg       <= 1'b0;
            gap_fill_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            nxt_reg           <= nxt_next;
            src_reg           <= src_next;
            started_reg       <= started_next;
            prev_valid_reg    <= prev_valid_next;
            prev_last_y_reg   <= prev_last_y_next;
            prev_count_reg    <= prev_count_next;
            curr_y_reg        <= curr_y_next;
            curr_count_reg    <= curr_count_next;
            curr_last_reg     <= curr_last_next;
            overflow_seen_reg <= overflow_seen_next;
            sel_reg           <= sel_next;
            idx_reg           <= idx_next;
            do_swap_reg       <= do_swap_next;
            gap_fill_reg      <= gap_fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sentinel_reg <= srre_pkg::SENTINEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            sentinel_reg <= cfg_wr_data;
        end
    end

    // accepted input word
    always_ff @(posedge clk)
    begin
        if ((state_reg == srre_pkg::S_IDLE) && in_valid)
        begin
            mode_reg  <= mode;
            x_reg     <= span_x;
            y_reg     <= span_y;
            right_reg <= right_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && out_free)
        begin
            word_reg  <= emit_word;
            last_reg  <= emit_last;
            empty_reg <= emit_empty;
            ovf_reg   <= overflow_seen_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;
    assign overflow  = ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (curr_count_reg <= CW'(MAX_XS_PER_LINE)) && (prev_count_reg <= CW'(MAX_XS_PER_LINE)))
        else $error("x count above line capacity");

    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        (curr_count_reg[0] == 1'b0) && (prev_count_reg[0] == 1'b0))
        else $error("odd x count");

    a_idle_region: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> ((curr_count_reg == '0) && !prev_valid_reg))
        else $error("line state present before the first span");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_free && emit_last) |=> !started_reg)
        else $error("region not cleared after final word");

endmodule
